/* rtl/core/utf8sc_pkg.sv */
// utf8sc_pkg: shared types, codes and the lead byte decode for the utf-8 stream checker
// no dependencies; used by every module under rtl/core
`timescale 1ns / 1ps

package utf8sc_pkg;

  typedef enum logic [2:0] {
    VERDICT_VALID     = 3'd0,
    VERDICT_ASCII     = 3'd1,
    VERDICT_BAD_LEAD  = 3'd2,
    VERDICT_BAD_CONT  = 3'd3,
    VERDICT_TRUNCATED = 3'd4
  } verdict_t;

  // error codes equal the verdict they cause
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_LEAD = 2'd2;
  localparam logic [1:0] ERR_BAD_CONT = 2'd3;

  localparam logic [2:0] PENDING_MAX = 3'd5;

  typedef struct packed {
    logic [2:0] pending;
    logic       ascii_only;
    logic [1:0] err;
  } chk_state_t;

  localparam chk_state_t STATE_RESET = '{pending: 3'd0, ascii_only: 1'b1, err: ERR_NONE};

  typedef struct packed {
    logic     is_utf8;
    verdict_t verdict;
  } chk_result_t;

  // continuation bytes that follow a lead byte, wide forms up to six bytes
  function automatic logic [2:0] lead_extra(input logic [7:0] b);
    logic [2:0] n;
    if (b == 8'hFC || b == 8'hFD) begin
      n = 3'd5;
    end else if (b >= 8'hF8) begin
      n = 3'd4;
    end else if (b >= 8'hF0) begin
      n = 3'd3;
    end else if (b >= 8'hE0) begin
      n = 3'd2;
    end else if (b >= 8'hC0) begin
      n = 3'd1;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

endpackage

/* rtl/core/utf8_stream_check_core.sv */
// utf8_stream_check_core: streaming utf-8 check of byte messages, top level
// depends on utf8sc_pkg, utf8sc_step and utf8sc_out_buf
`timescale 1ns / 1ps

// Takes one byte per cycle on the slave stream, tlast marking the final byte of a
// message, and gives one verdict transaction per message on the master stream:
// valid utf-8 with some non-ascii byte, all ascii, bad lead byte, bad continuation
// byte or truncated sequence. Lead bytes follow the wide forms of 2 to 6 bytes.
// A byte sits in the input register while the check state is updated, and the verdict
// appears on the master side at the edge where the last byte leaves that register.
// Throughput is one byte per cycle; only a master that stalls long enough to fill
// the two-entry verdict buffer holds back the slave side, and then only at a last byte.
module utf8_stream_check_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] is_utf8, [3:1] verdict, [7:4] zero
);
  import utf8sc_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;
  logic        can_push;
  chk_state_t  st;
  chk_state_t  st_next;
  chk_result_t res;
  chk_result_t out_res;

  // a last byte moves on only when the verdict buffer has room
  assign advance       = in_valid && (!in_last || can_push);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  utf8sc_step u_step (
    .state      (st),
    .data_byte  (in_byte),
    .last_byte  (in_last),
    .state_next (st_next),
    .result     (res)
  );

  utf8sc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && in_last),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {4'd0, out_res.verdict, out_res.is_utf8};

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    st.pending <= PENDING_MAX)
    else $error("pending count out of range");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    st.err == ERR_NONE || st.err == ERR_BAD_LEAD || st.err == ERR_BAD_CONT)
    else $error("undefined error code held");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> st == STATE_RESET)
    else $error("state not cleared after end of message");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    advance && !in_last && st.err != ERR_NONE |=> st.err == $past(st.err))
    else $error("recorded error changed inside a message");

  a_verdict_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[3:1] == VERDICT_VALID))
    else $error("is_utf8 disagrees with verdict");

endmodule

/* rtl/core/utf8sc_step.sv */
// utf8sc_step: combinational state update and verdict for one byte
// depends on utf8sc_pkg
`timescale 1ns / 1ps

module utf8sc_step (
  input  utf8sc_pkg::chk_state_t  state,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output utf8sc_pkg::chk_state_t  state_next,
  output utf8sc_pkg::chk_result_t result
);
  import utf8sc_pkg::*;

  chk_state_t upd;
  logic [2:0] extra;
  verdict_t   verdict;

  assign extra = lead_extra(data_byte);

  always_comb begin
    upd = state;
    if (state.err == ERR_NONE) begin
      if (data_byte[7]) begin
        upd.ascii_only = 1'b0;
      end
      if (state.pending == 3'd0) begin
        if (data_byte[7]) begin
          if (extra == 3'd0) begin
            upd.err = ERR_BAD_LEAD;
          end else begin
            upd.pending = extra;
          end
        end
      end else begin
        if (data_byte[7:6] != 2'b10) begin
          upd.err = ERR_BAD_CONT;
        end else begin
          upd.pending = state.pending - 3'd1;
        end
      end
    end
  end

  always_comb begin
    if (upd.err != ERR_NONE) begin
      verdict = verdict_t'({1'b0, upd.err});
    end else if (upd.pending != 3'd0) begin
      verdict = VERDICT_TRUNCATED;
    end else if (upd.ascii_only) begin
      verdict = VERDICT_ASCII;
    end else begin
      verdict = VERDICT_VALID;
    end
  end

  assign result.verdict = verdict;
  assign result.is_utf8 = (verdict == VERDICT_VALID);
  // end of message returns to the reset state
  assign state_next     = last_byte ? STATE_RESET : upd;

endmodule

/* rtl/core/utf8sc_out_buf.sv */
// utf8sc_out_buf: two-entry skid buffer holding verdicts for the master side
// depends on utf8sc_pkg
`timescale 1ns / 1ps

module utf8sc_out_buf (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  utf8sc_pkg::chk_result_t push_data,
  output logic                    can_push,
  output logic                    out_valid,
  input  logic                    out_ready,
  output utf8sc_pkg::chk_result_t out_data
);
  import utf8sc_pkg::*;

  logic        main_valid;
  logic        skid_valid;
  chk_result_t main_data;
  chk_result_t skid_data;
  logic        pop;

  assign pop       = main_valid && out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule
